// ===== src/assert_macros.svh =====
// Assertion macros shared by the distance block's RTL.
// No dependencies; synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/wmed_pkg.sv =====
// Shared constants and types of the weighted masked distance block.
// No dependencies.
package wmed_pkg;
	localparam int unsigned FEATURE_COUNT_DEF = 4096;
	localparam int unsigned IDX_W = 12;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned SCALE_W = 32;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned ACC_W = 64;
	localparam int unsigned FRAC_SHIFT = 20;
	localparam int unsigned SHIFTED_W = PROD_W - FRAC_SHIFT;

	// queue between front and back; a power of two so pointers wrap
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PAIR = 1'b1;

	localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

	// one feature pair after table lookup: sign and magnitude of the difference
	typedef struct packed {
		logic               neg;
		logic [VAL_W-1:0]   mag;
		logic [SCALE_W-1:0] scale;
		logic               last;
	} pair_t;

	// finished sum handed to the square root unit
	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             ovf;
	} root_req_t;
endpackage

// ===== src/wmed_front.sv =====
// Front end: input handshake, scale table with its clearing pass, difference.
// Depends on wmed_pkg.
module wmed_front import wmed_pkg::*; #(
	parameter int unsigned FEATURE_COUNT = FEATURE_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [IDX_W-1:0]          feature_index,
	input  logic signed [VAL_W-1:0]   value_a,
	input  logic signed [VAL_W-1:0]   value_b,
	input  logic [SCALE_W-1:0]        scale,
	input  logic                      last,
	input  logic [QCNT_W-1:0]         q_count,
	output logic                      q_push,
	output pair_t                     q_entry
);
	localparam int unsigned AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(FEATURE_COUNT - 1);

	logic [SCALE_W-1:0] table_q [FEATURE_COUNT];
	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;

	logic               accept;
	logic               in_range;
	logic [AW-1:0]      addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [SCALE_W-1:0] wr_data;
	logic signed [VAL_W:0] diff_ab;
	logic signed [VAL_W:0] diff_ba;
	logic [QCNT_W:0]    credit_used;

	logic               s1_valid_q;
	logic               neg_s1;
	logic               in_range_s1;
	logic               last_s1;
	logic [VAL_W-1:0]   mag_s1;
	logic [SCALE_W-1:0] rdata_s1;

	assign in_range = 32'(feature_index) < 32'(FEATURE_COUNT);
	assign addr     = AW'(feature_index);

	// take an item only if the queue has room for it and for the one in flight
	assign credit_used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_q);
	assign in_ready    = !clr_busy_q && (credit_used < (QCNT_W+1)'(QUEUE_DEPTH));
	assign accept      = in_valid && in_ready;

	assign wr_en   = clr_busy_q || (accept && (op == OP_LOAD) && in_range);
	assign wr_addr = clr_busy_q ? clr_addr_q : addr;
	assign wr_data = clr_busy_q ? '0 : scale;

	assign diff_ab = (VAL_W+1)'(value_a) - (VAL_W+1)'(value_b);
	assign diff_ba = (VAL_W+1)'(value_b) - (VAL_W+1)'(value_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
			s1_valid_q <= accept && (op == OP_PAIR);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		if (accept) begin
			rdata_s1    <= table_q[addr];
			neg_s1      <= diff_ab[VAL_W];
			mag_s1      <= diff_ab[VAL_W] ? diff_ba[VAL_W-1:0] : diff_ab[VAL_W-1:0];
			in_range_s1 <= in_range;
			last_s1     <= last;
		end
	end

	always_comb begin
		q_push        = s1_valid_q;
		q_entry.neg   = neg_s1;
		q_entry.mag   = mag_s1;
		q_entry.scale = in_range_s1 ? rdata_s1 : '0;
		q_entry.last  = last_s1;
	end
endmodule

// ===== src/wmed_fifo.sv =====
// Short queue of looked-up feature pairs between front and back.
// Depends on wmed_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wmed_fifo import wmed_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pair_t             entry_in,
	input  logic              pop,
	output pair_t             entry_out,
	output logic              not_empty,
	output logic [QCNT_W-1:0] count
);
	pair_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= entry_in;
		end
	end

	assign entry_out = slots_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	`ASSERT_NEVER(q_no_overflow, clk, arst_n, push && (count_q == QCNT_W'(QUEUE_DEPTH)), "queue written while full")
	`ASSERT_NEVER(q_no_underflow, clk, arst_n, pop && (count_q == '0), "queue read while empty")
endmodule

// ===== src/wmed_back.sv =====
// Back end: scale multiply, saturation, square and saturating accumulation.
// Depends on wmed_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wmed_back import wmed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  pair_t     q_entry,
	output logic      q_pop,
	input  logic      root_idle,
	output logic      root_start,
	output root_req_t root_req
);
	logic                 adv;

	logic                 valid_s1;
	logic [PROD_W-1:0]    prod_s1;
	logic                 neg_s1;
	logic                 last_s1;

	logic                 valid_s2;
	logic [VAL_W-1:0]     sat_mag_s2;
	logic                 sat_s2;
	logic                 last_s2;

	logic                 valid_s3;
	logic [ACC_W-1:0]     sq_s3;
	logic                 sat_s3;
	logic                 last_s3;

	logic [ACC_W-1:0]     sum_q;
	logic                 ovf_q;

	logic [SHIFTED_W-1:0] shifted;
	logic [VAL_W-1:0]     limit;
	logic                 over;
	logic [ACC_W-1:0]     sq_c;
	logic [ACC_W:0]       acc_sum;
	logic [ACC_W-1:0]     sum_next;
	logic                 ovf_next;

	// hold the whole back end while a finished sum waits for the root unit
	assign adv   = !(valid_s3 && last_s3 && !root_idle);
	assign q_pop = adv && q_valid;

	assign shifted = prod_s1[PROD_W-1:FRAC_SHIFT];
	assign limit   = neg_s1 ? NEG_LIMIT : POS_LIMIT;
	assign over    = shifted > SHIFTED_W'(limit);
	assign sq_c    = ACC_W'(sat_mag_s2) * ACC_W'(sat_mag_s2);

	assign acc_sum  = {1'b0, sum_q} + {1'b0, sq_s3};
	assign sum_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign ovf_next = ovf_q || sat_s3 || acc_sum[ACC_W];

	assign root_start   = adv && valid_s3 && last_s3;
	assign root_req.sum = sum_next;
	assign root_req.ovf = ovf_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			sum_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s3) begin
				// clear the sum once a vector comparison ends
				sum_q <= last_s3 ? '0 : sum_next;
				ovf_q <= last_s3 ? 1'b0 : ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1    <= PROD_W'(q_entry.mag) * PROD_W'(q_entry.scale);
			neg_s1     <= q_entry.neg;
			last_s1    <= q_entry.last;
			sat_mag_s2 <= over ? limit : shifted[VAL_W-1:0];
			sat_s2     <= over;
			last_s2    <= last_s1;
			sq_s3      <= sq_c;
			sat_s3     <= sat_s2;
			last_s3    <= last_s2;
		end
	end

	`ASSERT_NEXT(sum_cleared_after_last, clk, arst_n, root_start, (sum_q == '0) && !ovf_q, "sum not cleared after a result")
endmodule

// ===== src/wmed_sqrt.sv =====
// Bit-pair floor square root of the 64-bit sum, plus the result register.
// Depends on wmed_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wmed_sqrt import wmed_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  root_req_t        req,
	output logic             idle,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] dist_res,
	output logic             saturated
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] dist_res_q;
	logic             saturated_q;

	logic [ACC_W-1:0] rem_q;
	logic [ACC_W-1:0] root_q;
	logic [ACC_W-1:0] bit_q;
	logic             ovf_q;

	logic [ACC_W-1:0] trial;
	logic [ACC_W:0]   rem_diff;
	logic             take;
	logic [ACC_W-1:0] rem_nx;
	logic [ACC_W-1:0] root_nx;
	logic             out_free;
	logic             load_out;

	// root and bit never share a set bit, so OR forms their sum
	assign trial    = root_q | bit_q;
	assign rem_diff = {1'b0, rem_q} - {1'b0, trial};
	assign take     = !rem_diff[ACC_W];
	assign rem_nx   = take ? rem_diff[ACC_W-1:0] : rem_q;
	assign root_nx  = take ? ((root_q >> 1) | bit_q) : (root_q >> 1);
	assign out_free = !out_valid_q || out_ready;
	assign load_out = out_free && (((state_q == ST_RUN) && bit_q[0]) || (state_q == ST_HOLD));

	assign idle      = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign dist_res  = dist_res_q;
	assign saturated = saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dist_res_q  <= '0;
			saturated_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (bit_q[0]) begin
						if (out_free) begin
							dist_res_q  <= root_nx[VAL_W-1:0];
							saturated_q <= ovf_q;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						dist_res_q  <= root_q[VAL_W-1:0];
						saturated_q <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			rem_q  <= req.sum;
			root_q <= '0;
			bit_q  <= ACC_W'(1) << (ACC_W - 2);
			ovf_q  <= req.ovf;
		end else if (state_q == ST_RUN) begin
			rem_q  <= rem_nx;
			root_q <= root_nx;
			bit_q  <= bit_q >> 2;
		end
	end

	// the final remainder never reaches 2*root+1, else the root is too small
	`ASSERT_NEVER(root_rem_bound, clk, arst_n, (state_q == ST_RUN) && bit_q[0] && (rem_nx > {root_nx[ACC_W-2:0], 1'b0}), "square root remainder out of range")
endmodule

// ===== src/weighted_masked_euclidean_distance.sv =====
// Weighted masked Euclidean distance, top level; depends on wmed_pkg and the wmed_* modules.
// After reset all FEATURE_COUNT scale table entries (4096 by default) are swept to zero
// with in_ready low. Afterwards the block takes one item per cycle while in_ready is high: a load (op 0) writes
// one table entry, a pair (op 1) reads its entry, and a four-deep queue feeds the back end,
// which multiplies, saturates, squares and accumulates one pair per cycle unless stalled.
// A pair marked last hands its sum to a bit-pair square root unit, and the root runs while
// the next vector streams in.
// A second last pair reaching the accumulator while the root unit is still busy stalls the
// back end, and in_ready drops once the queue fills, until the unit frees.
module weighted_masked_euclidean_distance import wmed_pkg::*; #(
	parameter int unsigned FEATURE_COUNT = FEATURE_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [IDX_W-1:0]        feature_index,
	input  logic signed [VAL_W-1:0] value_a,
	input  logic signed [VAL_W-1:0] value_b,
	input  logic [SCALE_W-1:0]      scale,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [VAL_W-1:0]        dist_res,
	output logic                    saturated
);
	logic              q_push;
	pair_t             q_in;
	pair_t             q_out;
	logic              q_pop;
	logic              q_valid;
	logic [QCNT_W-1:0] q_count;
	logic              root_idle;
	logic              root_start;
	root_req_t         root_req;

	wmed_front #(
		.FEATURE_COUNT(FEATURE_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.feature_index(feature_index),
		.value_a      (value_a),
		.value_b      (value_b),
		.scale        (scale),
		.last         (last),
		.q_count      (q_count),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	wmed_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.entry_in (q_in),
		.pop      (q_pop),
		.entry_out(q_out),
		.not_empty(q_valid),
		.count    (q_count)
	);

	wmed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_out),
		.q_pop     (q_pop),
		.root_idle (root_idle),
		.root_start(root_start),
		.root_req  (root_req)
	);

	wmed_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.req      (root_req),
		.idle     (root_idle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dist_res (dist_res),
		.saturated(saturated)
	);
endmodule
